### rtl/assert_macros.svh
// Assertion helpers included by the thrust control unit.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequence must hold in the same cycle as the condition.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequence must hold in the cycle after the condition.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/aptc_pkg.sv
package aptc_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_POSITION  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_VELOCITY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEGRAL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCENT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ASCENT_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VEHICLE_MASS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD  = 3'd6;

   // Shared restoring divider geometry.
   localparam int DIV_REM_W = 34;
   localparam int DIV_DVD_W = 51;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LIMIT = 6'd48;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_ACCEL = 6'd51;

   // Fixed-point constants.
   localparam logic signed [63:0] GRAVITY_Q16 = 64'sd642908;
   localparam logic [64:0] TERM_CAP  = 65'h1 << 60;
   localparam logic [DIV_DVD_W-1:0] QUOT_CAP = 51'h1 << 50;
   localparam logic signed [63:0] INTEG_MAX = (64'sd1 <<< 47) - 64'sd1;
   localparam logic signed [63:0] INTEG_MIN = -(64'sd1 <<< 47);

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } aptc_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } aptc_div_stat_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LIM_ASC, S_LIM_ASC_WAIT, S_LIM_DSC, S_LIM_DSC_WAIT,
      S_IH, S_IL, S_PH, S_PL, S_VH, S_VL, S_GH, S_GL,
      S_WW, S_ZZ, S_XX, S_YY, S_SUMB, S_DEN, S_DIV, S_DIV_WAIT,
      S_CLAMP, S_TH, S_TL, S_TFIN
   } aptc_state_type;

endpackage

### rtl/aptc_req_if.sv
interface aptc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_height;
   logic signed [31:0] target_climb;
   logic signed [31:0] measured_height;
   logic signed [31:0] measured_climb;
   logic signed [31:0] feedforward_accel;
   logic signed [31:0] attitude_w;
   logic signed [31:0] attitude_x;
   logic signed [31:0] attitude_y;
   logic signed [31:0] attitude_z;

   modport source (
      output valid, target_height, target_climb, measured_height, measured_climb,
             feedforward_accel, attitude_w, attitude_x, attitude_y, attitude_z,
      input  ready
   );
   modport sink (
      input  valid, target_height, target_climb, measured_height, measured_climb,
             feedforward_accel, attitude_w, attitude_x, attitude_y, attitude_z,
      output ready
   );
endinterface

### rtl/aptc_rsp_if.sv
interface aptc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] thrust_command;
   logic               degenerate_tilt;

   modport source (output valid, thrust_command, degenerate_tilt, input ready);
   modport sink (input valid, thrust_command, degenerate_tilt, output ready);
endinterface

### rtl/aptc_divider.sv
module aptc_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  aptc_pkg::aptc_div_ctl_type          ctl,
   input  logic [aptc_pkg::DIV_REM_W-1:0]      divisor,
   input  logic [aptc_pkg::DIV_REM_W-1:0]      init_rem,
   input  logic [aptc_pkg::DIV_DVD_W-1:0]      dividend,
   output aptc_pkg::aptc_div_stat_type         stat,
   output logic [aptc_pkg::DIV_DVD_W-1:0]      quotient
);
   import aptc_pkg::*;

   logic [DIV_REM_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIV_DVD_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_REM_W:0]   shifted;
   logic                 fits;

   // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      shifted = {rem_ff, dvd_ff[DIV_DVD_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = init_rem;
         dsr_in  = divisor;
         dvd_in  = dividend;
         quo_in  = '0;
         cnt_in  = ctl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DIV_REM_W'(shifted - {1'b0, dsr_ff});
         end else begin
            rem_in = shifted[DIV_REM_W-1:0];
         end
         dvd_in = {dvd_ff[DIV_DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
endmodule

### rtl/altitude_pid_thrust_control_unit.sv
// Altitude PID thrust controller. One request is taken at a time and its thrust
// result is registered after these steps: the shared 32x32 multiplier forms the
// integral, the three PID terms and the quaternion squares, the tilt term is formed
// and the divider started, a restoring divider retires one quotient bit per cycle,
// then the clamp and the mass product follow. When the tilt term is zero the divider
// is skipped; when the quotient is known to saturate it is skipped too. The unit
// returns to idle, where the next request can be accepted, when the result is registered.
// The climb limits (rate / sample period) are held in registers; after reset and
// after every register write they are recomputed on the same divider, during which
// no request is accepted. A finished result waits in the output register; the next
// result is held back until it has been taken.
`include "assert_macros.svh"
module altitude_pid_thrust_control_unit (
   input  logic                               clock,
   input  logic                               reset,
   aptc_req_if.sink                           req_bus,
   aptc_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [aptc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aptc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import aptc_pkg::*;

   aptc_state_type state_ff, state_in;
   logic stale_ff, stale_in;

   // Configuration registers.
   logic [31:0] gp_ff, gv_ff, gi_ff, dsc_ff, asc_ff, mass_ff, sp_ff;
   logic [31:0] dt;

   // Datapath registers.
   logic signed [47:0] integ_ff, integ_in;
   logic signed [32:0] pe_ff, pe_in, ve_ff, ve_in;
   logic signed [63:0] num_ff, num_in;
   logic [31:0] wm_ff, wm_in, xm_ff, xm_in, ym_ff, ym_in, zm_ff, zm_in;
   logic [63:0] hold_ff, hold_in, prod_ff, prod_in, sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [33:0] dmag_ff, dmag_in;
   logic        dneg_ff, dneg_in, degen_ff, degen_in, nneg_ff, nneg_in;
   logic [61:0] nmag_ff, nmag_in;
   logic [DIV_DVD_W-1:0] q_ff, q_in;
   logic [47:0] asc_lim_ff, asc_lim_in, desc_lim_ff, desc_lim_in;
   logic [47:0] acc_mag_ff, acc_mag_in;
   logic        acc_neg_ff, acc_neg_in;
   logic signed [31:0] thrust_ff, thrust_in;
   logic        degen_out_ff, degen_out_in, rsp_valid_ff, rsp_valid_in;

   // Shared multiplier and divider hookup.
   logic [31:0] mul_a, mul_b;
   aptc_div_ctl_type  div_ctl;
   aptc_div_stat_type div_stat;
   logic [DIV_REM_W-1:0] div_divisor, div_init;
   logic [DIV_DVD_W-1:0] div_dividend, div_quot;

   // Helper values.
   logic        req_fire, out_free;
   logic [47:0] pe_mag, ve_mag, integ_mag;
   logic [60:0] term;
   logic        term_neg;
   logic signed [63:0] sterm, integ_sum;
   logic [63:0] num_abs;
   logic [DIV_DVD_W-1:0] qc;
   logic [47:0] lim;
   logic        acc_neg;

   // Saturated product magnitude from its high and low partial products.
   function automatic logic [60:0] term_cap(input logic [63:0] hi_p, input logic [63:0] lo_p);
      logic [64:0] t;
      t = {1'b0, hi_p} + {17'b0, lo_p[63:16]};
      term_cap = (t > TERM_CAP) ? TERM_CAP[60:0] : t[60:0];
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(~v + 32'sd1) : 32'(v);
   endfunction

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign dt = (sp_ff == 32'd0) ? 32'd1 : sp_ff;

   assign pe_mag    = {15'b0, pe_ff[32] ? 33'(-pe_ff) : 33'(pe_ff)};
   assign ve_mag    = {15'b0, ve_ff[32] ? 33'(-ve_ff) : 33'(ve_ff)};
   assign integ_mag = integ_ff[47] ? 48'(-integ_ff) : 48'(integ_ff);

   // Signed product term finished from the held and current partial products.
   always_comb begin
      term = term_cap(hold_ff, prod_ff);
      case (state_ff)
         S_GH:    term_neg = ve_ff[32];
         S_WW:    term_neg = integ_ff[47];
         default: term_neg = pe_ff[32];
      endcase
      sterm     = term_neg ? -$signed({3'b0, term}) : $signed({3'b0, term});
      integ_sum = 64'(integ_ff) + sterm;
      num_abs   = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
      qc        = (q_ff > QUOT_CAP) ? QUOT_CAP : q_ff;
      acc_neg   = nneg_ff ^ dneg_ff;
      lim       = acc_neg ? desc_lim_ff : asc_lim_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (stale_ff) begin
               state_in = S_LIM_ASC;
            end else if (req_fire) begin
               state_in = S_IH;
            end
         end
         S_LIM_ASC:      state_in = csr_we ? S_IDLE : S_LIM_ASC_WAIT;
         S_LIM_ASC_WAIT: begin
            if (csr_we) begin
               state_in = S_IDLE;
            end else if (div_stat.done) begin
               state_in = S_LIM_DSC;
            end
         end
         S_LIM_DSC:      state_in = csr_we ? S_IDLE : S_LIM_DSC_WAIT;
         S_LIM_DSC_WAIT: begin
            if (csr_we || div_stat.done) begin
               state_in = S_IDLE;
            end
         end
         S_IH:   state_in = S_IL;
         S_IL:   state_in = S_PH;
         S_PH:   state_in = S_PL;
         S_PL:   state_in = S_VH;
         S_VH:   state_in = S_VL;
         S_VL:   state_in = S_GH;
         S_GH:   state_in = S_GL;
         S_GL:   state_in = S_WW;
         S_WW:   state_in = S_ZZ;
         S_ZZ:   state_in = S_XX;
         S_XX:   state_in = S_YY;
         S_YY:   state_in = S_SUMB;
         S_SUMB: state_in = S_DEN;
         S_DEN:  state_in = S_DIV;
         S_DIV: begin
            if (degen_ff) begin
               state_in = S_TH;
            end else if ({7'b0, dmag_ff} <= nmag_ff[61:21]) begin
               state_in = S_CLAMP;
            end else begin
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: state_in = S_TH;
         S_TH:    state_in = S_TL;
         S_TL:    state_in = S_TFIN;
         S_TFIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: request ready, multiplier operands and divider commands.
   always_comb begin
      mul_a         = '0;
      mul_b         = '0;
      div_ctl.start = 1'b0;
      div_ctl.steps = DIV_STEPS_ACCEL;
      div_divisor   = dmag_ff;
      div_init      = nmag_ff[54:21];
      div_dividend  = {nmag_ff[20:0], 30'b0};
      req_bus.ready = (state_ff == S_IDLE) && !stale_ff;
      unique case (state_ff)
         S_LIM_ASC: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = DIV_STEPS_LIMIT;
            div_divisor   = {2'b0, dt};
            div_init      = '0;
            div_dividend  = {asc_ff, 19'b0};
         end
         S_LIM_DSC: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = DIV_STEPS_LIMIT;
            div_divisor   = {2'b0, dt};
            div_init      = '0;
            div_dividend  = {dsc_ff, 19'b0};
         end
         S_IH: begin mul_a = pe_mag[47:16];              mul_b = sp_ff;   end
         S_IL: begin mul_a = {16'b0, pe_mag[15:0]};      mul_b = sp_ff;   end
         S_PH: begin mul_a = pe_mag[47:16];              mul_b = gp_ff;   end
         S_PL: begin mul_a = {16'b0, pe_mag[15:0]};      mul_b = gp_ff;   end
         S_VH: begin mul_a = ve_mag[47:16];              mul_b = gv_ff;   end
         S_VL: begin mul_a = {16'b0, ve_mag[15:0]};      mul_b = gv_ff;   end
         S_GH: begin mul_a = integ_mag[47:16];           mul_b = gi_ff;   end
         S_GL: begin mul_a = {16'b0, integ_mag[15:0]};   mul_b = gi_ff;   end
         S_WW: begin mul_a = wm_ff;                      mul_b = wm_ff;   end
         S_ZZ: begin mul_a = zm_ff;                      mul_b = zm_ff;   end
         S_XX: begin mul_a = xm_ff;                      mul_b = xm_ff;   end
         S_YY: begin mul_a = ym_ff;                      mul_b = ym_ff;   end
         S_TH: begin mul_a = acc_mag_ff[47:16];          mul_b = mass_ff; end
         // The low mass product is kept in place while the result waits.
         S_TL, S_TFIN: begin
            mul_a = {16'b0, acc_mag_ff[15:0]};
            mul_b = mass_ff;
         end
         S_DIV: begin
            if (!degen_ff && ({7'b0, dmag_ff} > nmag_ff[61:21])) begin
               div_ctl.start = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign prod_in = {32'b0, mul_a} * {32'b0, mul_b};

   // Datapath next values.
   always_comb begin
      pe_in        = pe_ff;
      ve_in        = ve_ff;
      num_in       = num_ff;
      wm_in        = wm_ff;
      xm_in        = xm_ff;
      ym_in        = ym_ff;
      zm_in        = zm_ff;
      hold_in      = hold_ff;
      sqa_in       = sqa_ff;
      sqb_in       = sqb_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      degen_in     = degen_ff;
      nneg_in      = nneg_ff;
      nmag_in      = nmag_ff;
      q_in         = q_ff;
      asc_lim_in   = asc_lim_ff;
      desc_lim_in  = desc_lim_ff;
      acc_mag_in   = acc_mag_ff;
      acc_neg_in   = acc_neg_ff;
      integ_in     = integ_ff;
      thrust_in    = thrust_ff;
      degen_out_in = degen_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pe_in  = 33'(req_bus.target_height) - 33'(req_bus.measured_height);
               ve_in  = 33'(req_bus.target_climb) - 33'(req_bus.measured_climb);
               num_in = 64'(req_bus.feedforward_accel) - GRAVITY_Q16;
               wm_in  = mag32(req_bus.attitude_w);
               xm_in  = mag32(req_bus.attitude_x);
               ym_in  = mag32(req_bus.attitude_y);
               zm_in  = mag32(req_bus.attitude_z);
            end
         end
         S_LIM_ASC_WAIT: begin
            if (div_stat.done) begin
               asc_lim_in = div_quot[47:0];
            end
         end
         S_LIM_DSC_WAIT: begin
            if (div_stat.done) begin
               desc_lim_in = div_quot[47:0];
            end
         end
         S_IL, S_PL, S_VL, S_GL, S_TL: hold_in = prod_ff;
         S_PH: begin
            // Saturating integrator update.
            if (integ_sum > INTEG_MAX) begin
               integ_in = INTEG_MAX[47:0];
            end else if (integ_sum < INTEG_MIN) begin
               integ_in = INTEG_MIN[47:0];
            end else begin
               integ_in = integ_sum[47:0];
            end
         end
         S_VH, S_GH: num_in = num_ff + sterm;
         S_WW:   num_in = num_ff + sterm;
         S_ZZ:   sqa_in = prod_ff;
         S_XX:   sqa_in = sqa_ff + prod_ff;
         S_YY:   sqb_in = prod_ff;
         S_SUMB: sqb_in = sqb_ff + prod_ff;
         S_DEN: begin
            dneg_in  = sqa_ff < sqb_ff;
            dmag_in  = (sqa_ff < sqb_ff) ? 34'((sqb_ff - sqa_ff) >> 30)
                                         : 34'((sqa_ff - sqb_ff) >> 30);
            degen_in = ((sqa_ff < sqb_ff) ? (sqb_ff - sqa_ff) : (sqa_ff - sqb_ff)) < 64'h4000_0000;
            nneg_in  = num_ff[63];
            nmag_in  = num_abs[61:0];
         end
         S_DIV: begin
            // Zero tilt term picks the limit on the side of the numerator sign.
            if (degen_ff) begin
               acc_neg_in = nneg_ff;
               if (nmag_ff == '0) begin
                  acc_mag_in = '0;
               end else begin
                  acc_mag_in = nneg_ff ? desc_lim_ff : asc_lim_ff;
               end
            end else begin
               q_in = QUOT_CAP;
            end
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               q_in = div_quot;
            end
         end
         S_CLAMP: begin
            acc_neg_in = acc_neg;
            acc_mag_in = (qc > {3'b0, lim}) ? lim : qc[47:0];
         end
         S_TFIN: begin
            // Thrust is the negated mass product, saturated to 32 bits.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               degen_out_in = degen_ff;
               if (!acc_neg_ff) begin
                  thrust_in = (term > 61'h8000_0000) ? 32'sh8000_0000
                                                     : 32'(-$signed({1'b0, term}));
               end else begin
                  thrust_in = (term > 61'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(term);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign stale_in = csr_we ? 1'b1
                   : ((state_ff == S_LIM_DSC_WAIT) && div_stat.done) ? 1'b0 : stale_ff;

   // Control state, integrator and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         gp_ff        <= 32'd0;
         gv_ff        <= 32'd0;
         gi_ff        <= 32'd0;
         dsc_ff       <= 32'd6553600;
         asc_ff       <= 32'd6553600;
         mass_ff      <= 32'd65536;
         sp_ff        <= 32'd655;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GAIN_POSITION: gp_ff   <= csr_wdata;
               CSR_GAIN_VELOCITY: gv_ff   <= csr_wdata;
               CSR_GAIN_INTEGRAL: gi_ff   <= csr_wdata;
               CSR_DESCENT_LIMIT: dsc_ff  <= csr_wdata;
               CSR_ASCENT_LIMIT:  asc_ff  <= csr_wdata;
               CSR_VEHICLE_MASS:  mass_ff <= csr_wdata;
               CSR_SAMPLE_PERIOD: sp_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      pe_ff        <= pe_in;
      ve_ff        <= ve_in;
      num_ff       <= num_in;
      wm_ff        <= wm_in;
      xm_ff        <= xm_in;
      ym_ff        <= ym_in;
      zm_ff        <= zm_in;
      hold_ff      <= hold_in;
      prod_ff      <= prod_in;
      sqa_ff       <= sqa_in;
      sqb_ff       <= sqb_in;
      dmag_ff      <= dmag_in;
      dneg_ff      <= dneg_in;
      degen_ff     <= degen_in;
      nneg_ff      <= nneg_in;
      nmag_ff      <= nmag_in;
      q_ff         <= q_in;
      asc_lim_ff   <= asc_lim_in;
      desc_lim_ff  <= desc_lim_in;
      acc_mag_ff   <= acc_mag_in;
      acc_neg_ff   <= acc_neg_in;
      thrust_ff    <= thrust_in;
      degen_out_ff <= degen_out_in;
   end

   aptc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .divisor  (div_divisor),
      .init_rem (div_init),
      .dividend (div_dividend),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.thrust_command  = thrust_ff;
   assign rsp_bus.degenerate_tilt = degen_out_ff;

   // A request never overlaps one in flight, and stale limits hold requests off.
   `ASSERT_NXT(a_busy_after_req, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   `ASSERT_IMP(a_stale_blocks, clock, reset, stale_ff, !req_bus.ready)
   `ASSERT_IMP(a_acc_in_limit, clock, reset, state_ff == S_TH, acc_mag_ff <= (acc_neg_ff ? desc_lim_ff : asc_lim_ff))
endmodule
